[src/cpdr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdr_pkg: shared types and constants of the resync checksum deframer
// Word formats, operation and event codes, buffer geometry and the ring
// pointer wrap helper.
// ----------------------------------------------------------------------------
package cpdr_pkg;

    localparam int BUF_DEPTH   = 32;
    localparam int MAX_PAYLOAD = 7;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int FILL_W      = $clog2(BUF_DEPTH + 1);
    localparam int TBL_DEPTH   = 256;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_REQ   = 2'd2;
    localparam logic [1:0] OP_TABLE = 2'd3;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_RESPONSE  = 2'd1;
    localparam logic [1:0] EV_UNSOLICIT = 2'd2;
    localparam logic [1:0] EV_RECOVERED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  byte_value;
        logic [2:0]  entry_length;
        logic [15:0] entry_timeout;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  packet_id;
        logic [2:0]  payload_len;
        logic [55:0] payload;
        logic        send_ping;
        logic        read_out_of_sync;
        logic        write_out_of_sync;
        logic        sync_recovered;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [15:0] timeout;
    } tbl_entry_t;

    function automatic logic [BUF_AW-1:0] buf_wrap(input logic [BUF_AW:0] s);
        logic [BUF_AW:0] r;
        begin
            r = s;
            if (s >= (BUF_AW + 1)'(BUF_DEPTH))
            begin
                r = s - (BUF_AW + 1)'(BUF_DEPTH);
            end
            return r[BUF_AW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/checksum_packet_deframer_resync_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// checksum_packet_deframer_resync_core: sliding resync checksum deframer
// Buffers received bytes and scans for id/payload/check packets.
// ----------------------------------------------------------------------------
// One word is taken at a time and in_ready stays low until its result has
// been handed to the output register. A table write or request set goes
// straight to the result; a poll that checks the timeout takes the timeout
// step first. A received byte or a poll with bytes buffered runs a scan: each
// candidate head position takes a buffer read, a table read, then one byte a
// cycle through the single 8-bit checksum adder. The buffer is a ring in a RAM
// with one read port, which sets the one-byte-per-cycle pace. A result that
// waits at the output blocks the next word from being accepted until the
// output register can take a new result.
module checksum_packet_deframer_resync_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire cpdr_pkg::in_word_t  in_data,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      cpdr_pkg::out_word_t out_data,
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [7:0]          cfg_data
);
    import cpdr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_HEAD = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_TOUT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [BUF_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [7:0]        sum_reg, sum_next;
    logic [2:0]        plen_reg, plen_next;
    logic [7:0]        id_reg, id_next;
    logic [55:0]       payload_reg, payload_next;
    logic [1:0]        ev_reg, ev_next;
    logic              ping_reg, ping_next;
    logic [2:0]        flags_reg, flags_next;
    logic              pending_reg, pending_next;
    logic [7:0]        req_id_reg, req_id_next;
    logic [15:0]       poll_reg, poll_next;
    logic [7:0]        ping_id_reg;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg, out_data_next;

    logic              accept;
    logic              buf_wr_en;
    logic [BUF_AW-1:0] buf_wr_addr;
    logic [BUF_AW-1:0] buf_rd_addr;
    logic [7:0]        buf_rdata;
    logic              tbl_wr_en;
    tbl_entry_t        tbl_wr_data;
    logic [7:0]        tbl_rd_addr;
    tbl_entry_t        tbl_rd;
    logic [2:0]        clip_len;
    logic [2:0]        pidx;
    logic [15:0]       poll_inc;
    logic              out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign buf_wr_en   = accept && (in_data.op == OP_BYTE) && (fill_reg < FILL_W'(BUF_DEPTH));
    assign buf_wr_addr = buf_wrap({1'b0, head_reg} + (BUF_AW + 1)'(fill_reg));

    always_comb
    begin
        unique case (state_reg)
            ST_LEN:  buf_rd_addr = buf_wrap({1'b0, head_reg} + (BUF_AW + 1)'(1));
            ST_SUM:  buf_rd_addr = buf_wrap({1'b0, head_reg} + (BUF_AW + 1)'(cnt_reg)
                                            + (BUF_AW + 1)'(1));
            default: buf_rd_addr = head_reg;
        endcase
    end

    cpdr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_rx_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (in_data.byte_value),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rdata)
    );

    assign clip_len = (in_data.entry_length > 3'(MAX_PAYLOAD)) ? 3'(MAX_PAYLOAD)
                                                              : in_data.entry_length;
    assign tbl_wr_en           = accept && (in_data.op == OP_TABLE);
    assign tbl_wr_data.len     = clip_len;
    assign tbl_wr_data.timeout = in_data.entry_timeout;
    assign tbl_rd_addr         = (state_reg == ST_HEAD) ? buf_rdata : req_id_reg;

    cpdr_len_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (in_data.byte_value),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd)
    );

    assign pidx     = cnt_reg[2:0] - 3'd1;
    assign poll_inc = (poll_reg == 16'hFFFF) ? poll_reg : poll_reg + 16'd1;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        plen_next    = plen_reg;
        id_next      = id_reg;
        payload_next = payload_reg;
        ev_next      = ev_reg;
        ping_next    = ping_reg;
        flags_next   = flags_reg;
        pending_next = pending_reg;
        req_id_next  = req_id_reg;
        poll_next    = poll_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ev_next   = EV_NONE;
                    ping_next = 1'b0;
                    unique case (in_data.op)
                        OP_BYTE:
                        begin
                            if (buf_wr_en)
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            state_next = ST_SCAN;
                        end
                        OP_POLL:
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                            else if (pending_reg)
                            begin
                                state_next = ST_TOUT;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_REQ:
                        begin
                            pending_next = 1'b1;
                            req_id_next  = in_data.byte_value;
                            state_next   = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                payload_next = '0;
                state_next   = (fill_reg == '0) ? ST_DONE : ST_HEAD;
            end
            ST_HEAD:
            begin
                id_next    = buf_rdata;
                sum_next   = buf_rdata;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                plen_next = tbl_rd.len;
                cnt_next  = 4'd1;
                if (fill_reg < FILL_W'(tbl_rd.len) + FILL_W'(2))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (cnt_reg <= {1'b0, plen_reg})
                begin
                    sum_next                       = sum_reg + buf_rdata;
                    payload_next[{pidx, 3'b000} +: 8] = buf_rdata;
                    cnt_next                       = cnt_reg + 4'd1;
                end
                else if (~sum_reg == buf_rdata)
                begin
                    head_next = buf_wrap({1'b0, head_reg} + (BUF_AW + 1)'(plen_reg)
                                         + (BUF_AW + 1)'(2));
                    fill_next = fill_reg - FILL_W'(plen_reg) - FILL_W'(2);
                    if (pending_reg && (id_reg == req_id_reg))
                    begin
                        ev_next      = EV_RESPONSE;
                        flags_next   = 3'b000;
                        pending_next = 1'b0;
                    end
                    else if ((flags_reg[0] || flags_reg[1]) && (id_reg == ping_id_reg))
                    begin
                        ev_next    = EV_RECOVERED;
                        flags_next = 3'b100;
                    end
                    else
                    begin
                        ev_next = EV_UNSOLICIT;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    if (!flags_reg[0])
                    begin
                        flags_next[0] = 1'b1;
                        poll_next     = '0;
                        ping_next     = 1'b1;
                    end
                    head_next  = buf_wrap({1'b0, head_reg} + (BUF_AW + 1)'(1));
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_TOUT:
            begin
                poll_next = poll_inc;
                if (poll_inc > tbl_rd.timeout)
                begin
                    flags_next[1] = 1'b1;
                    poll_next     = '0;
                    ping_next     = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next                  = 1'b1;
            out_data_next.event_res         = ev_reg;
            out_data_next.packet_id         = (ev_reg == EV_NONE) ? 8'd0 : id_reg;
            out_data_next.payload_len       = (ev_reg == EV_NONE) ? 3'd0 : plen_reg;
            out_data_next.payload           = (ev_reg == EV_NONE) ? 56'd0 : payload_reg;
            out_data_next.send_ping         = ping_reg;
            out_data_next.read_out_of_sync  = flags_reg[0];
            out_data_next.write_out_of_sync = flags_reg[1];
            out_data_next.sync_recovered    = flags_reg[2];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            ev_reg        <= EV_NONE;
            ping_reg      <= 1'b0;
            flags_reg     <= '0;
            pending_reg   <= 1'b0;
            req_id_reg    <= '0;
            poll_reg      <= '0;
            ping_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            ev_reg        <= ev_next;
            ping_reg      <= ping_next;
            flags_reg     <= flags_next;
            pending_reg   <= pending_next;
            req_id_reg    <= req_id_next;
            poll_reg      <= poll_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ping_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        sum_reg      <= sum_next;
        plen_reg     <= plen_next;
        id_reg       <= id_next;
        payload_reg  <= payload_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

[src/cpdr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[src/cpdr_len_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdr_len_table: per-id payload length and timeout table
// A RAM with one valid bit per id; an id never written reads as zero.
// ----------------------------------------------------------------------------
module cpdr_len_table (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [7:0]            wr_addr,
    input  wire cpdr_pkg::tbl_entry_t  wr_data,
    input  wire logic [7:0]            rd_addr,
    output      cpdr_pkg::tbl_entry_t  rd_data
);
    import cpdr_pkg::*;

    logic [TBL_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;
    tbl_entry_t           ram_rdata;

    cpdr_ram #(
        .WIDTH ($bits(tbl_entry_t)),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? ram_rdata : '0;

endmodule
`default_nettype wire
